// ----- rtl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer package
// Shared types and constants for the line request path from the front end,
// through the command queue, to the stepping back end.
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int unsigned COORD_W   = 5;
	localparam int unsigned SPAN_W    = 6;
	localparam int unsigned INDEX_W   = 10;
	localparam int unsigned GRID_W    = 6;
	localparam int unsigned QDEPTH    = 2;
	localparam logic [GRID_W-1:0] GRID_RESET = 6'd28;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t                    origin_x;
		coord_t                    origin_y;
		logic signed [SPAN_W-1:0]  span_x;
		logic signed [SPAN_W-1:0]  span_y;
		coord_t                    step_total;
	} line_cmd_t;

endpackage

// ----- rtl/line_pixel_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer
// Steps a line between two grid endpoints and emits each point with its
// linear grid index, a clip flag and an end-of-line mark.
//
//  Channel  Signals                                   Direction
//  input    in_valid, in_stall, start_x/y, end_x/y    request in
//  output   out_valid, out_stall, pixel_x/y,          point out
//           pixel_index, inside_res, last
//  config   cfg_wen, cfg_wdata (grid_size)            write only
//
// A line of S steps gives S+1 points, one per cycle while the output is not
// stalled, once the back end has taken the command from the queue in its idle
// state. Reset returns the grid size to 28 and empties the queue.
// A stall on the output holds the stepper; the queue and front register go
// on taking up to three requests meanwhile.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer #(
	parameter int unsigned GRID_MAX = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [lpr_pkg::GRID_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lpr_pkg::coord_t             start_x,
	input  lpr_pkg::coord_t             start_y,
	input  lpr_pkg::coord_t             end_x,
	input  lpr_pkg::coord_t             end_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lpr_pkg::coord_t             pixel_x,
	output lpr_pkg::coord_t             pixel_y,
	output logic [lpr_pkg::INDEX_W-1:0] pixel_index,
	output logic                        inside_res,
	output logic                        last
);
	import lpr_pkg::*;

	logic      push_valid;
	logic      push_ready;
	line_cmd_t push_cmd;
	logic      cmd_valid;
	logic      cmd_pop;
	line_cmd_t cmd;

	lpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	lpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (cmd_valid),
		.pop       (cmd_pop),
		.pop_cmd   (cmd)
	);

	lpr_back #(
		.GRID_MAX(GRID_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_index(pixel_index),
		.inside_res (inside_res),
		.last       (last)
	);

endmodule

// ----- rtl/lpr_front.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer front end
// Takes line requests, works out signed spans and the step count, and holds
// the resulting command in one register stage until the queue takes it.
// ----------------------------------------------------------------------------
module lpr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lpr_pkg::coord_t    start_x,
	input  lpr_pkg::coord_t    start_y,
	input  lpr_pkg::coord_t    end_x,
	input  lpr_pkg::coord_t    end_y,
	output logic               push_valid,
	input  logic               push_ready,
	output lpr_pkg::line_cmd_t push_cmd
);
	import lpr_pkg::*;

	logic                     valid_s1;
	line_cmd_t                cmd_s1;
	line_cmd_t                cmd_new;
	logic signed [SPAN_W-1:0] dx;
	logic signed [SPAN_W-1:0] dy;
	logic [SPAN_W-1:0]        abs_x;
	logic [SPAN_W-1:0]        abs_y;
	logic                     accept;
	logic                     push;

	always_comb begin
		dx = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		abs_x = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
		abs_y = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
		cmd_new.origin_x = start_x;
		cmd_new.origin_y = start_y;
		cmd_new.span_x = dx;
		cmd_new.span_y = dy;
		cmd_new.step_total = (abs_x > abs_y) ? abs_x[COORD_W-1:0] : abs_y[COORD_W-1:0];
	end

	assign push       = valid_s1 && push_ready;
	assign in_stall   = valid_s1 && !push_ready;
	assign accept     = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

// ----- rtl/lpr_queue.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer command queue
// A short first-in first-out buffer of line commands between front and back.
// ----------------------------------------------------------------------------
module lpr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  lpr_pkg::line_cmd_t push_cmd,
	output logic               pop_valid,
	input  logic               pop,
	output lpr_pkg::line_cmd_t pop_cmd
);
	import lpr_pkg::*;

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	line_cmd_t        entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/lpr_back.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer back end
// Walks one line command step by step with an exact quotient and remainder
// per axis, clips each point against the grid and registers the result.
// ----------------------------------------------------------------------------
module lpr_back #(
	parameter int unsigned GRID_MAX = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [lpr_pkg::GRID_W-1:0] cfg_wdata,
	input  logic                      cmd_valid,
	output logic                      cmd_pop,
	input  lpr_pkg::line_cmd_t        cmd,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lpr_pkg::coord_t           pixel_x,
	output lpr_pkg::coord_t           pixel_y,
	output logic [lpr_pkg::INDEX_W-1:0] pixel_index,
	output logic                      inside_res,
	output logic                      last
);
	import lpr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_state_t;

	localparam logic [6:0] GMAX = 7'(GRID_MAX);

	back_state_t              state_q;
	logic [GRID_W-1:0]        grid_size_q;
	logic                     out_valid_q;
	coord_t                   qx_q;
	coord_t                   qy_q;
	coord_t                   rx_q;
	coord_t                   ry_q;
	coord_t                   step_q;
	coord_t                   total_q;
	logic signed [SPAN_W-1:0] dx_q;
	logic signed [SPAN_W-1:0] dy_q;
	coord_t                   px_q;
	coord_t                   py_q;
	logic [INDEX_W-1:0]       index_q;
	logic                     inside_q;
	logic                     last_q;

	logic       advance;
	logic       at_last;
	logic [6:0] grid_eff;
	logic       in_grid;
	logic [11:0] index_full;
	logic [9:0] next_x;
	logic [9:0] next_y;

	function automatic logic [9:0] dda_next(input coord_t q, input coord_t r,
		input logic signed [SPAN_W-1:0] d, input coord_t s);
		logic signed [6:0] sum;
		logic signed [6:0] s7;
		logic signed [6:0] diff;
		logic signed [6:0] wrap;
		coord_t nq;
		coord_t nr;
		s7   = $signed({2'b00, s});
		sum  = $signed({2'b00, r}) + $signed({d[SPAN_W-1], d});
		diff = sum - s7;
		wrap = sum + s7;
		nq   = q;
		nr   = sum[COORD_W-1:0];
		if (!d[SPAN_W-1] && (sum >= s7)) begin
			nq = q + 1'b1;
			nr = diff[COORD_W-1:0];
		end else if (d[SPAN_W-1] && sum[6]) begin
			nq = q - 1'b1;
			nr = wrap[COORD_W-1:0];
		end
		return {nq, nr};
	endfunction

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign advance = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	assign at_last = (step_q == total_q);

	always_comb begin
		grid_eff   = ({1'b0, grid_size_q} > GMAX) ? GMAX : {1'b0, grid_size_q};
		in_grid    = ({2'b00, qx_q} < grid_eff) && ({2'b00, qy_q} < grid_eff);
		index_full = 12'(qy_q) * 12'(grid_eff) + 12'(qx_q);
		next_x     = dda_next(qx_q, rx_q, dx_q, total_q);
		next_y     = dda_next(qy_q, ry_q, dy_q, total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grid_size_q <= GRID_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				grid_size_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (advance && at_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			qx_q    <= cmd.origin_x;
			qy_q    <= cmd.origin_y;
			rx_q    <= '0;
			ry_q    <= '0;
			dx_q    <= cmd.span_x;
			dy_q    <= cmd.span_y;
			total_q <= cmd.step_total;
			step_q  <= '0;
		end else if (advance) begin
			qx_q   <= next_x[9:5];
			rx_q   <= next_x[4:0];
			qy_q   <= next_y[9:5];
			ry_q   <= next_y[4:0];
			step_q <= step_q + 1'b1;
		end
		if (advance) begin
			px_q     <= qx_q;
			py_q     <= qy_q;
			inside_q <= in_grid;
			index_q  <= in_grid ? index_full[INDEX_W-1:0] : '0;
			last_q   <= at_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_index = index_q;
	assign inside_res  = inside_q;
	assign last        = last_q;

endmodule
